### hw/rtl/kcc_pkg.sv
// Shared types and constants for the key click classifier.
`default_nettype none
package kcc_pkg;

   localparam int COUNT_WIDTH = 8;
   localparam int REG_WIDTH   = 8;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;
   localparam int IDX_WIDTH   = 2;

   localparam logic [REG_WIDTH-1:0] DEBOUNCE_RESET = REG_WIDTH'(5);
   localparam logic [REG_WIDTH-1:0] LONG_RESET     = REG_WIDTH'(80);
   localparam logic [REG_WIDTH-1:0] WINDOW_RESET   = REG_WIDTH'(45);

   localparam logic [IDX_WIDTH-1:0] REG_DEBOUNCE = IDX_WIDTH'(0);
   localparam logic [IDX_WIDTH-1:0] REG_LONG     = IDX_WIDTH'(1);
   localparam logic [IDX_WIDTH-1:0] REG_WINDOW   = IDX_WIDTH'(2);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_SINGLE = 2'd1,
      ACT_DOUBLE = 2'd2,
      ACT_LONG   = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'b0001,
      PH_PRESSED  = 4'b0010,
      PH_RELEASED = 4'b0100,
      PH_WAITREL  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] debounce_ticks;
      logic [REG_WIDTH-1:0] long_press_ticks;
      logic [REG_WIDTH-1:0] double_window_ticks;
   } cfg_type;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
   endfunction

endpackage
`default_nettype wire

### hw/rtl/key_click_classifier_top.sv
// Key click classifier: one action word per sampled key word.
// The action word is registered and appears on rsp_ in the cycle after the key word is accepted.
// Throughput: one word per cycle while the output is not stalled; the state update is combinational logic.
// The input is stalled only while the output register holds a word that is stalled.
// Synchronous reset returns to idle, clears counters and loads default thresholds.
`default_nettype none
module key_click_classifier_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_key_level,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [1:0]                    rsp_action,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [kcc_pkg::IDX_WIDTH-1:0] csr_index,
   input  wire logic [kcc_pkg::REG_WIDTH-1:0] csr_wdata
);
   import kcc_pkg::*;

   cfg_type    cfg;
   action_type action;
   logic       step;
   logic       rsp_valid_ff, rsp_valid_in;
   action_type rsp_action_ff;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign step      = req_valid & ~req_stall;

   kcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kcc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .key_level (req_key_level),
      .cfg       (cfg),
      .action    (action)
   );

   assign rsp_valid_in = step | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_action_ff <= action;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;

endmodule
`default_nettype wire

### hw/rtl/kcc_csr.sv
// Threshold registers written through the csr port.
`default_nettype none
module kcc_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   input  wire logic [kcc_pkg::IDX_WIDTH-1:0] csr_index,
   input  wire logic [kcc_pkg::REG_WIDTH-1:0] csr_wdata,
   output kcc_pkg::cfg_type                  cfg
);
   import kcc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_DEBOUNCE: cfg_in.debounce_ticks      = csr_wdata;
            REG_LONG:     cfg_in.long_press_ticks    = csr_wdata;
            REG_WINDOW:   cfg_in.double_window_ticks = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks      <= DEBOUNCE_RESET;
         cfg_ff.long_press_ticks    <= LONG_RESET;
         cfg_ff.double_window_ticks <= WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### hw/rtl/kcc_core.sv
// Press/release state machine: one step per accepted key word.
`default_nettype none
module kcc_core (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire logic         key_level,
   input  wire kcc_pkg::cfg_type cfg,
   output kcc_pkg::action_type action
);
   import kcc_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] held_ff, held_in;
   logic [COUNT_WIDTH-1:0] gap_ff, gap_in;
   logic                   pending_ff, pending_in;
   logic [COUNT_WIDTH-1:0] held_inc, gap_inc;
   logic                   pressed;
   logic                   held_ge_long, held_ge_deb, gap_inc_ge_win, gap_lt_win;

   assign pressed  = ~key_level;
   assign held_inc = sat_inc(held_ff);
   assign gap_inc  = sat_inc(gap_ff);

   assign held_ge_long   = CMP_WIDTH'(held_inc) >= CMP_WIDTH'(cfg.long_press_ticks);
   assign held_ge_deb    = CMP_WIDTH'(held_ff)  >= CMP_WIDTH'(cfg.debounce_ticks);
   assign gap_inc_ge_win = CMP_WIDTH'(gap_inc)  >= CMP_WIDTH'(cfg.double_window_ticks);
   assign gap_lt_win     = CMP_WIDTH'(gap_ff)   <  CMP_WIDTH'(cfg.double_window_ticks);

   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      gap_in     = gap_ff;
      pending_in = pending_ff;
      action     = ACT_NONE;
      case (phase_ff)
         PH_IDLE: begin
            if (pressed) begin
               held_in  = '0;
               phase_in = PH_PRESSED;
            end
         end
         PH_PRESSED: begin
            if (pressed) begin
               held_in = held_inc;
               if (held_ge_long) begin
                  action     = ACT_LONG;
                  pending_in = 1'b0;
                  phase_in   = PH_WAITREL;
               end
            end else if (held_ge_deb) begin
               if (!pending_ff) begin
                  pending_in = 1'b1;
                  gap_in     = '0;
                  phase_in   = PH_RELEASED;
               end else begin
                  action     = ACT_DOUBLE;
                  pending_in = 1'b0;
                  phase_in   = PH_IDLE;
               end
            end else begin
               // bounce: drop it along with any pending click
               pending_in = 1'b0;
               phase_in   = PH_IDLE;
            end
         end
         PH_RELEASED: begin
            if (pressed) begin
               if (gap_lt_win) begin
                  action     = ACT_DOUBLE;
                  pending_in = 1'b0;
                  phase_in   = PH_IDLE;
               end else begin
                  if (pending_ff) begin
                     action     = ACT_SINGLE;
                     pending_in = 1'b0;
                  end
                  held_in  = '0;
                  phase_in = PH_PRESSED;
               end
            end else begin
               gap_in = gap_inc;
               if (gap_inc_ge_win) begin
                  if (pending_ff) begin
                     action     = ACT_SINGLE;
                     pending_in = 1'b0;
                  end
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_WAITREL: begin
            if (!pressed) phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         held_ff    <= '0;
         gap_ff     <= '0;
         pending_ff <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         gap_ff     <= gap_in;
         pending_ff <= pending_in;
      end
   end

endmodule
`default_nettype wire

### bench/tb_key_click_classifier_top.sv
// Self-checking bench for the key click classifier: gesture stimulus, action predictor.
`default_nettype none
module tb_key_click_classifier_top;
   timeunit 1ns;
   timeprecision 1ps;

   import kcc_pkg::*;

   localparam logic [IDX_WIDTH-1:0] REG_SPARE = IDX_WIDTH'(3);
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_KEYS  = 90;
   localparam int LEN_CAP     = 300;
   localparam int NUM_PHASES  = 12;

   // Tracks the classifier state and the action words still owed by the block.
   class click_predictor;
      cfg_type                cfg;
      phase_type              phase;
      logic [COUNT_WIDTH-1:0] held;
      logic [COUNT_WIDTH-1:0] gap;
      logic                   click_pending;
      action_type             actions_due[$];
      int                     mismatches;

      function new();
         cfg           = {DEBOUNCE_RESET, LONG_RESET, WINDOW_RESET};
         phase         = PH_IDLE;
         held          = '0;
         gap           = '0;
         click_pending = 1'b0;
         mismatches    = 0;
      endfunction

      function void note_reg(logic [IDX_WIDTH-1:0] idx, logic [REG_WIDTH-1:0] val);
         case (idx)
            REG_DEBOUNCE: cfg.debounce_ticks      = val;
            REG_LONG:     cfg.long_press_ticks    = val;
            REG_WINDOW:   cfg.double_window_ticks = val;
            default: ;
         endcase
      endfunction

      function logic [COUNT_WIDTH-1:0] count_up(logic [COUNT_WIDTH-1:0] v);
         return (v == CNT_MAX) ? v : v + 1'b1;
      endfunction

      function void note_key(logic level);
         logic       pressed;
         action_type act;
         pressed = (level == 1'b0);
         act     = ACT_NONE;
         case (phase)
            PH_IDLE: begin
               if (pressed) begin
                  held  = '0;
                  phase = PH_PRESSED;
               end
            end
            PH_PRESSED: begin
               if (pressed) begin
                  held = count_up(held);
                  if (held >= cfg.long_press_ticks) begin
                     act           = ACT_LONG;
                     click_pending = 1'b0;
                     phase         = PH_WAITREL;
                  end
               end else if (held >= cfg.debounce_ticks) begin
                  if (!click_pending) begin
                     click_pending = 1'b1;
                     gap           = '0;
                     phase         = PH_RELEASED;
                  end else begin
                     act           = ACT_DOUBLE;
                     click_pending = 1'b0;
                     phase         = PH_IDLE;
                  end
               end else begin
                  // bounce: drop the press and any pending click
                  click_pending = 1'b0;
                  phase         = PH_IDLE;
               end
            end
            PH_RELEASED: begin
               if (pressed) begin
                  if (gap < cfg.double_window_ticks) begin
                     act           = ACT_DOUBLE;
                     click_pending = 1'b0;
                     phase         = PH_IDLE;
                  end else begin
                     // window already over (lowered window): flush single, start new press
                     if (click_pending) begin
                        act           = ACT_SINGLE;
                        click_pending = 1'b0;
                     end
                     held  = '0;
                     phase = PH_PRESSED;
                  end
               end else begin
                  gap = count_up(gap);
                  if (gap >= cfg.double_window_ticks) begin
                     if (click_pending) begin
                        act           = ACT_SINGLE;
                        click_pending = 1'b0;
                     end
                     phase = PH_IDLE;
                  end
               end
            end
            PH_WAITREL: begin
               if (!pressed) phase = PH_IDLE;
            end
            default: ;
         endcase
         actions_due.push_back(act);
      endfunction

      function void check_action(logic [1:0] seen);
         action_type want;
         if (actions_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("action word %0d arrived with nothing outstanding", seen);
            return;
         end
         want = actions_due.pop_front();
         if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("action mismatch: expected %0d (%s), got %0d",
                        want, want.name(), seen);
         end
      endfunction

      function int outstanding();
         return actions_due.size();
      endfunction
   endclass

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic                 req_key_level = 1'b1;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic [1:0]           rsp_action;
   logic                 csr_valid     = 1'b0;
   logic                 csr_ready;
   logic [IDX_WIDTH-1:0] csr_index     = '0;
   logic [REG_WIDTH-1:0] csr_wdata     = '0;

   click_predictor board;
   int idle_mode  = 1;
   int stall_left = 0;
   int keys_sent  = 0;
   int cycles     = 0;

   key_click_classifier_top i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_key_level (req_key_level),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_action    (rsp_action),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side: check accepted words, then drive random stall bursts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_action(rsp_action);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (idle_mode != 0 && $urandom_range(0, idle_mode * 4) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_key(logic level);
      if (idle_mode != 0 && $urandom_range(0, idle_mode * 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_key_level <= level;
      do @(posedge clock); while (req_stall);
      board.note_key(level);
      keys_sent++;
   endtask

   task automatic send_pattern(string levels);
      for (int i = 0; i < levels.len(); i++)
         send_key(levels[i] == "1");
   endtask

   // Lower the sender and wait until every owed action word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [IDX_WIDTH-1:0] idx, logic [REG_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      board.note_reg(idx, val);
   endtask

   task automatic load_settings(logic [REG_WIDTH-1:0] deb, logic [REG_WIDTH-1:0] lng,
                                logic [REG_WIDTH-1:0] win);
      logic [REG_WIDTH-1:0] vals[3];
      logic [IDX_WIDTH-1:0] regs[3];
      int                   first;
      vals  = '{deb, lng, win};
      regs  = '{REG_DEBOUNCE, REG_LONG, REG_WINDOW};
      first = $urandom_range(0, 2);
      if ($urandom_range(0, 1))
         write_reg(REG_SPARE, REG_WIDTH'($urandom));
      for (int i = 0; i < 3; i++)
         write_reg(regs[(first + i) % 3], vals[(first + i) % 3]);
      csr_valid <= 1'b0;
   endtask

   // One press/release gesture sized around the current thresholds, or noise.
   task automatic play_gesture();
      int deb, lng, win, lo, hi, n_press, n_rel;
      deb = board.cfg.debounce_ticks;
      lng = board.cfg.long_press_ticks;
      win = board.cfg.double_window_ticks;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 16)) send_key(1'($urandom_range(0, 1)));
      end else begin
         case ($urandom_range(0, 2))
            0: n_press = $urandom_range(1, (deb < 1) ? 1 : deb);
            1: begin
               hi = (lng < 1) ? 1 : lng;
               lo = (deb + 1 > hi) ? hi : deb + 1;
               n_press = $urandom_range(lo, hi);
            end
            default: n_press = lng + 1 + $urandom_range(0, 3);
         endcase
         if ($urandom_range(0, 1))
            n_rel = $urandom_range(1, (win < 1) ? 1 : win);
         else
            n_rel = win + 1 + $urandom_range(0, 4);
         repeat ((n_press > LEN_CAP) ? LEN_CAP : n_press) send_key(1'b0);
         repeat ((n_rel > LEN_CAP) ? LEN_CAP : n_rel) send_key(1'b1);
      end
   endtask

   initial begin
      int                   target;
      logic [REG_WIDTH-1:0] deb, lng;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset thresholds: debounce met exactly, then a second press inside the window
      send_pattern("00000010");
      drain();
      // single, double, long, bounce, then a click left pending
      load_settings(8'd1, 8'd2, 8'd2);
      send_pattern("0011100100001010011");
      // shrink the window under the pending click: the next press flushes a single
      drain();
      write_reg(REG_WINDOW, 8'd1);
      csr_valid <= 1'b0;
      send_key(1'b0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         case (p)
            0: load_settings(8'd0, 8'd0, 8'd0);
            1: load_settings(8'd255, 8'd255, 8'd255);
            2: load_settings(8'd1, 8'd1, 8'd1);
            3: load_settings(DEBOUNCE_RESET, LONG_RESET, WINDOW_RESET);
            4: load_settings(8'd1, 8'd255, 8'd255);
            default: begin
               deb = REG_WIDTH'($urandom_range(1, 6));
               lng = REG_WIDTH'($urandom_range(deb, 40));
               load_settings(deb, lng, REG_WIDTH'($urandom_range(2, 20)));
            end
         endcase
         idle_mode = (p == NUM_PHASES - 1) ? 0 : $urandom_range(0, 3);
         target    = keys_sent + PHASE_KEYS;
         while (keys_sent < target) play_gesture();
      end

      drain();
      repeat (4) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire

### key_click_classifier_top.f
hw/rtl/kcc_pkg.sv
hw/rtl/kcc_csr.sv
hw/rtl/kcc_core.sv
hw/rtl/key_click_classifier_top.sv
bench/tb_key_click_classifier_top.sv
